### src/ppti_pkg.sv
// ppti_pkg: item types and result codes shared by the text image parser
// depends on: nothing
package ppti_pkg;

    // ascii codes the parser looks for
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_THREE   = 8'h33;

    // decimal numbers saturate here
    localparam logic [15:0] NUM_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } result_kind_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       file_start;
    } in_item_t;

    typedef struct packed {
        result_kind_t result_kind;
        logic [15:0]  header_width;
        logic [15:0]  header_height;
        logic [15:0]  header_max_color;
        logic [15:0]  inv_red;
        logic [15:0]  inv_green;
        logic [15:0]  inv_blue;
        logic [15:0]  pixel_line;
        logic [15:0]  pixel_column;
    } out_item_t;

endpackage

### src/ppm_text_parse_invert_core.sv
// a result is registered and offered in the cycle after the byte that completes it is taken
// throughput: one byte per cycle; the single result register stalls input only while
// a held result is not taken
// reset: rst_n clears parser state to the magic line and empties the result register
// ppm_text_parse_invert_core: top level, byte channel in, result channel out
// depends on: ppti_pkg, ppti_parser
module ppm_text_parse_invert_core
    import ppti_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int DIM_BITS    = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  in_item_t  byte_item,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res_item
);

    logic      accept;
    logic      hit;
    out_item_t res;
    logic      res_valid_reg, res_valid_next;
    out_item_t res_item_reg;

    // take a byte whenever the result register is empty or being drained
    assign byte_ready = !res_valid_reg || res_ready;
    assign accept     = byte_valid && byte_ready;

    ppti_parser #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DIM_BITS    (DIM_BITS)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (accept),
        .item  (byte_item),
        .hit   (hit),
        .res   (res)
    );

    // result register valid
    always_comb
    begin
        if (byte_ready)
            res_valid_next = accept && hit;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept && hit)
            res_item_reg <= res;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // a produced result is offered next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && hit) |=> res_valid)
        else $error("result lost");

    // a byte with no result leaves the register empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !hit) |=> !res_valid)
        else $error("spurious result");

    // an offered item is the one captured at that accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && hit) |=> (res_item == $past(res)))
        else $error("result payload mismatch");

endmodule

### src/ppti_parser.sv
// ppti_parser: byte-wide parser state for text images, header decode and pixel invert
// depends on: ppti_pkg
module ppti_parser
    import ppti_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int DIM_BITS    = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  in_item_t  item,
    output logic      hit,
    output out_item_t res
);

    typedef enum logic [2:0] {
        PH_MAGIC = 3'd0,
        PH_SIZE  = 3'd1,
        PH_MAXC  = 3'd2,
        PH_BODY  = 3'd3,
        PH_HALT  = 3'd4
    } phase_t;

    localparam logic [15:0] DimLim =
        (DIM_BITS >= 16) ? 16'hFFFF : 16'((1 << DIM_BITS) - 1);
    localparam logic [15:0] SampleLim = 16'((1 << SAMPLE_BITS) - 1);

    phase_t                   phase_reg, phase_next, cur_phase;
    logic [1:0]               char_reg, char_next, cur_char, char_inc;
    logic                     comment_reg, comment_next, cur_comment, comment_now;
    logic                     number_reg, number_next, cur_number;
    logic [15:0]              accum_reg, accum_next, cur_accum, acc_sat;
    logic [19:0]              acc_wide;
    logic [1:0]               comp_reg, comp_next, cur_comp;
    logic [SAMPLE_BITS-1:0]   red_reg, red_next, cur_red;
    logic [SAMPLE_BITS-1:0]   green_reg, green_next, cur_green;
    logic [15:0]              width_reg, width_next, cur_width;
    logic [15:0]              height_reg, height_next, cur_height;
    logic [SAMPLE_BITS-1:0]   maxc_reg, maxc_next, cur_maxc;
    logic [15:0]              line_reg, line_next, cur_line;
    logic [15:0]              col_reg, col_next, cur_col;
    logic                     is_digit, is_nl, header, active;
    logic [3:0]               digit;

    // clamp a number to the sample range
    function automatic logic [SAMPLE_BITS-1:0] clamp_sample(input logic [15:0] v);
        return (v > SampleLim) ? SampleLim[SAMPLE_BITS-1:0] : v[SAMPLE_BITS-1:0];
    endfunction

    // max color minus sample, floored at zero
    function automatic logic [15:0] invert(input logic [SAMPLE_BITS-1:0] maxc,
                                           input logic [SAMPLE_BITS-1:0] s);
        logic [SAMPLE_BITS-1:0] d;
        d = (maxc > s) ? (maxc - s) : '0;
        return 16'(d);
    endfunction

    // a file start restarts the parser before its byte is handled
    always_comb
    begin
        if (item.file_start)
        begin
            cur_phase   = PH_MAGIC;
            cur_char    = '0;
            cur_comment = 1'b0;
            cur_number  = 1'b0;
            cur_accum   = '0;
            cur_comp    = '0;
            cur_red     = '0;
            cur_green   = '0;
            cur_width   = '0;
            cur_height  = '0;
            cur_maxc    = '0;
            cur_line    = '0;
            cur_col     = '0;
        end
        else
        begin
            cur_phase   = phase_reg;
            cur_char    = char_reg;
            cur_comment = comment_reg;
            cur_number  = number_reg;
            cur_accum   = accum_reg;
            cur_comp    = comp_reg;
            cur_red     = red_reg;
            cur_green   = green_reg;
            cur_width   = width_reg;
            cur_height  = height_reg;
            cur_maxc    = maxc_reg;
            cur_line    = line_reg;
            cur_col     = col_reg;
        end
    end

    // decimal accumulate with saturation
    assign is_digit = (item.text_byte >= CHAR_ZERO) && (item.text_byte <= CHAR_NINE);
    assign is_nl    = (item.text_byte == CHAR_NEWLINE);
    assign digit    = 4'(item.text_byte - CHAR_ZERO);
    assign acc_wide = cur_number ? ({4'b0, cur_accum} * 20'd10 + 20'(digit)) : 20'(digit);
    assign acc_sat  = (acc_wide > 20'(NUM_MAX)) ? NUM_MAX : acc_wide[15:0];
    assign char_inc = (cur_char == 2'd3) ? 2'd3 : cur_char + 2'd1;
    assign header   = (cur_phase != PH_BODY);
    assign active   = (cur_phase == PH_MAGIC) || (cur_phase == PH_SIZE) ||
                      (cur_phase == PH_MAXC) || (cur_phase == PH_BODY);
    assign comment_now = cur_comment ||
                         (header && (cur_char == 2'd0) && (item.text_byte == CHAR_HASH));

    // next state and result for one byte
    always_comb
    begin
        phase_next   = cur_phase;
        char_next    = cur_char;
        comment_next = cur_comment;
        number_next  = cur_number;
        accum_next   = cur_accum;
        comp_next    = cur_comp;
        red_next     = cur_red;
        green_next   = cur_green;
        width_next   = cur_width;
        height_next  = cur_height;
        maxc_next    = cur_maxc;
        line_next    = cur_line;
        col_next     = cur_col;
        hit          = 1'b0;
        res          = '0;

        if (!active)
        begin
            // halted: ignore everything
        end
        else if (header && comment_now)
        begin
            // skip a header comment line
            comment_next = !is_nl;
            char_next    = is_nl ? 2'd0 : char_inc;
        end
        else if (cur_phase == PH_MAGIC)
        begin
            if (((cur_char == 2'd1) && (item.text_byte != CHAR_THREE)) ||
                (is_nl && (cur_char < 2'd2)))
            begin
                hit             = 1'b1;
                res.result_kind = KIND_ERROR;
                phase_next      = PH_HALT;
            end
            else if (is_nl)
            begin
                phase_next = PH_SIZE;
                char_next  = 2'd0;
                comp_next  = 2'd0;
            end
            else
            begin
                char_next = char_inc;
            end
        end
        else
        begin
            // number accumulate, or hand over a finished number
            if (is_digit)
            begin
                accum_next  = acc_sat;
                number_next = 1'b1;
            end
            else if (cur_number)
            begin
                number_next = 1'b0;
                accum_next  = '0;
                if (cur_phase == PH_SIZE)
                begin
                    if (cur_comp == 2'd0)
                        width_next = (cur_accum > DimLim) ? DimLim : cur_accum;
                    else if (cur_comp == 2'd1)
                        height_next = (cur_accum > DimLim) ? DimLim : cur_accum;
                    if (cur_comp < 2'd2)
                        comp_next = cur_comp + 2'd1;
                end
                else if (cur_phase == PH_MAXC)
                begin
                    if (cur_comp == 2'd0)
                        maxc_next = clamp_sample(cur_accum);
                    comp_next = 2'd1;
                end
                else if (cur_comp == 2'd0)
                begin
                    red_next  = clamp_sample(cur_accum);
                    comp_next = 2'd1;
                end
                else if (cur_comp == 2'd1)
                begin
                    green_next = clamp_sample(cur_accum);
                    comp_next  = 2'd2;
                end
                else
                begin
                    hit              = 1'b1;
                    res.result_kind  = KIND_PIXEL;
                    res.inv_red      = invert(cur_maxc, cur_red);
                    res.inv_green    = invert(cur_maxc, cur_green);
                    res.inv_blue     = invert(cur_maxc, clamp_sample(cur_accum));
                    res.pixel_line   = cur_line;
                    res.pixel_column = cur_col;
                    col_next         = cur_col + 16'd1;
                    comp_next        = 2'd0;
                end
            end

            // line ends move the phase or the line tag
            if (is_nl)
            begin
                char_next = 2'd0;
                if (cur_phase == PH_SIZE)
                begin
                    phase_next = PH_MAXC;
                    comp_next  = 2'd0;
                end
                else if (cur_phase == PH_MAXC)
                begin
                    phase_next           = PH_BODY;
                    comp_next            = 2'd0;
                    hit                  = 1'b1;
                    res.result_kind      = KIND_HEADER;
                    res.header_width     = width_next;
                    res.header_height    = height_next;
                    res.header_max_color = 16'(maxc_next);
                end
                else
                begin
                    line_next = cur_line + 16'd1;
                    col_next  = 16'd0;
                end
            end
            else if (header)
            begin
                char_next = char_inc;
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC;
            char_reg    <= '0;
            comment_reg <= 1'b0;
            number_reg  <= 1'b0;
            accum_reg   <= '0;
            comp_reg    <= '0;
            red_reg     <= '0;
            green_reg   <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            maxc_reg    <= '0;
            line_reg    <= '0;
            col_reg     <= '0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            char_reg    <= char_next;
            comment_reg <= comment_next;
            number_reg  <= number_next;
            accum_reg   <= accum_next;
            comp_reg    <= comp_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            maxc_reg    <= maxc_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
        end
    end

    // header result moves the parser into the body
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && hit && (res.result_kind == KIND_HEADER)) |=> (phase_reg == PH_BODY))
        else $error("header result without entering body");

    // format error halts the parser
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && hit && (res.result_kind == KIND_ERROR)) |=> (phase_reg == PH_HALT))
        else $error("format error without halt");

    // halted parser stays silent until the next file
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !item.file_start && (phase_reg == PH_HALT)) |-> !hit)
        else $error("result while halted");

endmodule

### test/ppm_text_parse_invert_core_tb.sv
`timescale 1ns / 1ps
// ppm_text_parse_invert_core_tb: feeds text image files byte by byte and checks header,
// inverted pixel and format error items against an internal parser
// depends on: ppti_pkg, ppm_text_parse_invert_core
module ppm_text_parse_invert_core_tb;
    import ppti_pkg::*;

    localparam int TARGET_BYTES = 1650;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SHOWN_ERRORS = 30;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_SIZE,
        PH_MAXC,
        PH_BODY,
        PH_HALT
    } parse_phase_t;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_ready;
    in_item_t  byte_item  = '0;
    logic      res_valid;
    logic      res_ready  = 1'b0;
    out_item_t res_item;

    // mirror of the parser state
    parse_phase_t ps_phase;
    logic [1:0]   ps_lead;
    logic         ps_comment;
    logic         ps_in_num;
    logic [15:0]  ps_num;
    logic [1:0]   ps_comp;
    logic [15:0]  ps_red;
    logic [15:0]  ps_green;
    logic [15:0]  ps_width;
    logic [15:0]  ps_height;
    logic [15:0]  ps_maxc;
    logic [15:0]  ps_line;
    logic [15:0]  ps_column;

    out_item_t   parsed_records[$];
    logic [7:0]  doc_bytes[$];

    int  mismatches  = 0;
    int  bytes_sent  = 0;
    int  n_headers   = 0;
    int  n_pixels    = 0;
    int  n_errors    = 0;
    int  cycle_count = 0;
    int  stall_left  = 0;
    bit  fast_source = 1'b0;
    bit  sink_stalls = 1'b0;

    ppm_text_parse_invert_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // parser mirror
    // ---------------------------------------------------------------

    function automatic void clear_parse_state();
        ps_phase   = PH_MAGIC;
        ps_lead    = 2'd0;
        ps_comment = 1'b0;
        ps_in_num  = 1'b0;
        ps_num     = 16'd0;
        ps_comp    = 2'd0;
        ps_red     = 16'd0;
        ps_green   = 16'd0;
        ps_width   = 16'd0;
        ps_height  = 16'd0;
        ps_maxc    = 16'd0;
        ps_line    = 16'd0;
        ps_column  = 16'd0;
    endfunction

    // max colour minus sample, floored at zero
    function automatic logic [15:0] invert_sample(input logic [15:0] s);
        return (ps_maxc > s) ? ps_maxc - s : 16'd0;
    endfunction

    // consumes one byte; returns 1 when the byte completes a record
    function automatic bit parse_char(input logic [7:0] c, input logic restart,
                                      output out_item_t rec);
        bit          digit;
        bit          nl;
        bit          hdr;
        bit          got;
        logic [31:0] acc;
        got   = 1'b0;
        rec   = '0;
        digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        nl    = (c == CHAR_NEWLINE);
        if (restart)
            clear_parse_state();
        if (ps_phase == PH_HALT)
            return 1'b0;
        hdr = (ps_phase != PH_BODY);

        // a header line opening with a hash is a comment up to the newline
        if (hdr && ps_lead == 2'd0 && !nl && c == CHAR_HASH)
            ps_comment = 1'b1;
        if (hdr && ps_comment)
        begin
            if (nl)
            begin
                ps_comment = 1'b0;
                ps_lead    = 2'd0;
            end
            else if (ps_lead < 2'd3)
                ps_lead++;
            return 1'b0;
        end

        // magic line: second char must be a three, and the line must hold at least two chars
        if (ps_phase == PH_MAGIC)
        begin
            if ((ps_lead == 2'd1 && c != CHAR_THREE) || (nl && ps_lead < 2'd2))
            begin
                rec.result_kind = KIND_ERROR;
                ps_phase        = PH_HALT;
                return 1'b1;
            end
            if (nl)
            begin
                ps_phase = PH_SIZE;
                ps_lead  = 2'd0;
                ps_comp  = 2'd0;
            end
            else if (ps_lead < 2'd3)
                ps_lead++;
            return 1'b0;
        end

        // decimal accumulate, saturating; any other byte closes the number
        if (digit)
        begin
            acc       = ps_in_num ? ps_num * 32'd10 + (c - CHAR_ZERO) : c - CHAR_ZERO;
            ps_num    = (acc > 32'd65535) ? NUM_MAX : acc[15:0];
            ps_in_num = 1'b1;
        end
        else if (ps_in_num)
        begin
            ps_in_num = 1'b0;
            // clamps to DIM_BITS and SAMPLE_BITS are identity at 16 bits
            case (ps_phase)
                PH_SIZE:
                begin
                    if (ps_comp == 2'd0)
                        ps_width = ps_num;
                    else if (ps_comp == 2'd1)
                        ps_height = ps_num;
                    if (ps_comp < 2'd2)
                        ps_comp++;
                end
                PH_MAXC:
                begin
                    if (ps_comp == 2'd0)
                        ps_maxc = ps_num;
                    ps_comp = 2'd1;
                end
                default:
                begin
                    if (ps_comp == 2'd0)
                    begin
                        ps_red  = ps_num;
                        ps_comp = 2'd1;
                    end
                    else if (ps_comp == 2'd1)
                    begin
                        ps_green = ps_num;
                        ps_comp  = 2'd2;
                    end
                    else
                    begin
                        rec.result_kind  = KIND_PIXEL;
                        rec.inv_red      = invert_sample(ps_red);
                        rec.inv_green    = invert_sample(ps_green);
                        rec.inv_blue     = invert_sample(ps_num);
                        rec.pixel_line   = ps_line;
                        rec.pixel_column = ps_column;
                        ps_column++;
                        ps_comp = 2'd0;
                        got     = 1'b1;
                    end
                end
            endcase
            ps_num = 16'd0;
        end

        // line ends move the header along or bump the body line
        if (nl)
        begin
            ps_lead = 2'd0;
            if (ps_phase == PH_SIZE)
            begin
                ps_phase = PH_MAXC;
                ps_comp  = 2'd0;
            end
            else if (ps_phase == PH_MAXC)
            begin
                ps_phase             = PH_BODY;
                ps_comp              = 2'd0;
                rec                  = '0;
                rec.result_kind      = KIND_HEADER;
                rec.header_width     = ps_width;
                rec.header_height    = ps_height;
                rec.header_max_color = ps_maxc;
                got                  = 1'b1;
            end
            else
            begin
                ps_line++;
                ps_column = 16'd0;
            end
        end
        else if (hdr && ps_lead < 2'd3)
            ps_lead++;
        return got;
    endfunction

    // ---------------------------------------------------------------
    // item watch: predict on byte accept, compare on result accept
    // ---------------------------------------------------------------

    task automatic check_field(input string fld, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
        end
    endtask

    always @(posedge clk)
    begin : watch_items
        out_item_t rec;
        out_item_t want;
        if (rst_n && byte_valid && byte_ready)
        begin
            if (parse_char(byte_item.text_byte, byte_item.file_start, rec))
                parsed_records.push_back(rec);
        end
        if (rst_n && res_valid && res_ready)
        begin
            if (parsed_records.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("%0t: unpredicted result item, expected none, actual kind %0d",
                             $time, res_item.result_kind);
            end
            else
            begin
                want = parsed_records.pop_front();
                case (want.result_kind)
                    KIND_HEADER: n_headers++;
                    KIND_PIXEL:  n_pixels++;
                    default:     n_errors++;
                endcase
                check_field("result_kind", {14'd0, want.result_kind},
                            {14'd0, res_item.result_kind});
                check_field("header_width", want.header_width, res_item.header_width);
                check_field("header_height", want.header_height, res_item.header_height);
                check_field("header_max_color", want.header_max_color,
                            res_item.header_max_color);
                check_field("inv_red", want.inv_red, res_item.inv_red);
                check_field("inv_green", want.inv_green, res_item.inv_green);
                check_field("inv_blue", want.inv_blue, res_item.inv_blue);
                check_field("pixel_line", want.pixel_line, res_item.pixel_line);
                check_field("pixel_column", want.pixel_column, res_item.pixel_column);
            end
        end
    end

    // result side back-pressure: short stalls mostly, a few long ones
    always @(posedge clk)
    begin : sink_pace
        int r;
        if (stall_left > 0)
        begin
            res_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res_ready <= 1'b1;
            if (sink_stalls)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    stall_left <= $urandom_range(8, 30);
                else if (r < 25)
                    stall_left <= $urandom_range(1, 3);
            end
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d items outstanding", $time, parsed_records.size());
            $display("ppm_text_parse_invert_core verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // byte driver and document builders
    // ---------------------------------------------------------------

    task automatic send_byte(input logic [7:0] ch, input logic restart);
        in_item_t item;
        item.text_byte = ch;
        item.file_start = restart;
        byte_valid <= 1'b1;
        byte_item  <= item;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic idle_gap();
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!fast_source)
        begin
            if (r >= 90)
                gap = $urandom_range(8, 30);
            else if (r >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // first byte of each document restarts the parser
    task automatic send_doc(input int stop_at);
        for (int i = 0; i < stop_at; i++)
        begin
            send_byte(doc_bytes[i], i == 0);
            idle_gap();
        end
    endtask

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            doc_bytes.push_back(s[i]);
    endfunction

    function automatic void push_num(input int unsigned v);
        if ($urandom_range(0, 19) == 0)
            push_str("0");
        push_str($sformatf("%0d", v));
    endfunction

    // any non-digit, non-newline separator, mostly a space
    function automatic logic [7:0] rand_sep();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 60)
            return " ";
        if (r < 70)
            return "\t";
        if (r < 78)
            return "\r";
        if (r < 84)
            return "#";
        do
            b = 8'($urandom_range(0, 255));
        while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_NEWLINE);
        return b;
    endfunction

    function automatic void push_comments();
        while ($urandom_range(0, 99) < 20)
        begin
            push_str("#");
            repeat ($urandom_range(0, 6))
                doc_bytes.push_back(8'($urandom_range(32, 126)));
            push_str("\n");
        end
    endfunction

    function automatic int unsigned rand_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 640);
        if (r < 90)
            return $urandom_range(0, 65535);
        return $urandom_range(65536, 9999999);
    endfunction

    function automatic int unsigned rand_maxc();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 255;
        if (r < 65)
            return $urandom_range(1, 1023);
        if (r < 75)
            return 65535;
        if (r < 80)
            return 0;
        if (r < 85)
            return 1;
        if (r < 95)
            return $urandom_range(0, 65535);
        return $urandom_range(65536, 999999);
    endfunction

    function automatic int unsigned rand_sample(input int unsigned maxc);
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(0, maxc);
        if (r < 75)
            return 0;
        if (r < 85)
            return maxc;
        if (r < 93)
            return $urandom_range(0, 65535);
        return $urandom_range(65536, 9999999);
    endfunction

    // well-formed files mostly, some broken magic and raw noise
    task automatic build_random_doc();
        int          r;
        int unsigned maxc;
        int          nsamp;
        logic [7:0]  b;
        doc_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            repeat ($urandom_range(1, 16))
                doc_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        push_comments();
        if (r < 14)
        begin
            // wrong second magic char, or magic line cut short
            case ($urandom_range(0, 2))
                0:
                begin
                    push_str("P");
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CHAR_THREE);
                    doc_bytes.push_back(b);
                end
                1: push_str("P");
                default: ;
            endcase
            push_str("\n1 2\n3\n4 5 6\n");
            return;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CHAR_NEWLINE || b == CHAR_HASH);
            doc_bytes.push_back(b);
        end
        else
            push_str("P");
        push_str("3");
        repeat ($urandom_range(0, 2))
            doc_bytes.push_back(rand_sep());
        push_str("\n");

        // size line, sometimes short or with extras
        push_comments();
        if ($urandom_range(0, 3) == 0)
            doc_bytes.push_back(rand_sep());
        if ($urandom_range(0, 9) != 0)
        begin
            push_num(rand_dim());
            doc_bytes.push_back(rand_sep());
            if ($urandom_range(0, 19) != 0)
                push_num(rand_dim());
            if ($urandom_range(0, 6) == 0)
            begin
                doc_bytes.push_back(rand_sep());
                push_num(rand_dim());
            end
        end
        push_str("\n");

        // max colour line
        push_comments();
        maxc = rand_maxc();
        if ($urandom_range(0, 19) != 0)
            push_num(maxc);
        if ($urandom_range(0, 6) == 0)
        begin
            doc_bytes.push_back(rand_sep());
            push_num(rand_dim());
        end
        push_str("\n");
        if (maxc > 65535)
            maxc = 65535;

        // body samples with random separators and line breaks
        nsamp = 3 * $urandom_range(0, 12) + (($urandom_range(0, 4) == 0) ? 1 : 0);
        for (int i = 0; i < nsamp; i++)
        begin
            push_num(rand_sample(maxc));
            if ($urandom_range(0, 99) < 12)
                push_str("\n");
            else
                doc_bytes.push_back(rand_sep());
        end
        r = $urandom_range(0, 99);
        if (r < 70)
            push_str("\n");
        else if (r < 85)
            push_num(rand_sample(maxc));
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // unsupported magic, halted parser ignoring bytes, magic line too short
    task automatic test_magic_errors();
        doc_bytes.delete();
        push_str("P6x");
        send_doc(doc_bytes.size());
        doc_bytes.delete();
        push_str("\n");
        send_doc(doc_bytes.size());
    endtask

    // header comment, one pixel, a sample that saturates
    task automatic test_minimal_image();
        doc_bytes.delete();
        push_str("P3\n#\n1 2\n9\n9 0 70000\n");
        send_doc(doc_bytes.size());
    endtask

    // random documents, some cut off so the next file restarts mid-stream
    task automatic test_random_documents();
        int stop_at;
        while (bytes_sent < TARGET_BYTES)
        begin
            build_random_doc();
            fast_source = ($urandom_range(0, 4) == 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            stop_at     = doc_bytes.size();
            if ($urandom_range(0, 9) == 0)
                stop_at = $urandom_range(1, doc_bytes.size());
            send_doc(stop_at);
        end
        fast_source = 1'b0;
        sink_stalls = 1'b1;
    endtask

    initial
    begin
        clear_parse_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_magic_errors();
        test_minimal_image();
        test_random_documents();
        byte_valid <= 1'b0;

        // let the last byte's prediction land, drain outstanding items, then watch for strays
        @(posedge clk);
        while (parsed_records.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("parsed %0d bytes across header, comment, body and bad-magic files",
                 bytes_sent);
        $display("checked %0d header, %0d pixel and %0d error items, %0d mismatches",
                 n_headers, n_pixels, n_errors, mismatches);
        if (mismatches == 0)
            $display("ppm_text_parse_invert_core verification clean");
        else
            $display("ppm_text_parse_invert_core verification failed");
        $finish;
    end

endmodule

### files.f
src/ppti_pkg.sv
src/ppti_parser.sv
src/ppm_text_parse_invert_core.sv
test/ppm_text_parse_invert_core_tb.sv
